@@ sv/sliding_window_mean_variance_defines.svh @@
// Assertion macros for the sliding window mean/variance block.
// Used by the checker; expects clk and rst_n in the enclosing scope.
`ifndef SLIDING_WINDOW_MEAN_VARIANCE_DEFINES_SVH
`define SLIDING_WINDOW_MEAN_VARIANCE_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define SWMV_ASSERT_IMM(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("swmv assertion failed");

// Next-cycle implication, disabled while in reset.
`define SWMV_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("swmv assertion failed");

`endif

@@ sv/swmv_pkg.sv @@
// Shared constants for the sliding window mean/variance block.
// No dependencies; used by the interfaces, the top level and the checker.
`timescale 1ns / 1ps
`default_nettype none

package swmv_pkg;

  localparam int SAMPLE_W  = 10;  // sample_value width
  localparam int MEAN_W    = 18;  // window_mean width
  localparam int VAR_W     = 26;  // window_variance width
  localparam int USED_W    = 7;   // samples_used width
  localparam int FRAC_BITS = 8;   // fraction bits of mean and variance

endpackage

`default_nettype wire

@@ sv/swmv_if.sv @@
// Valid/ready channel interfaces for samples and statistics results.
// Depends on swmv_pkg for payload widths.
`timescale 1ns / 1ps
`default_nettype none

interface swmv_in_if;
  import swmv_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample_value;

  modport source (output valid, output sample_value, input ready);
  modport sink   (input valid, input sample_value, output ready);
endinterface

interface swmv_out_if;
  import swmv_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] window_mean;
  logic        [VAR_W-1:0]  window_variance;
  logic        [USED_W-1:0] samples_used;

  modport source (output valid, output window_mean, output window_variance,
                  output samples_used, input ready);
  modport sink   (input valid, input window_mean, input window_variance,
                  input samples_used, output ready);
endinterface

`default_nettype wire

@@ sv/swmv_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swmv_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 100
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ sv/swmv_div.sv @@
// Restoring divider, one quotient bit per cycle.
// Caller guarantees the quotient fits in Q_W bits. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module swmv_div #(
  parameter int NUM_W = 27,
  parameter int DEN_W = 8,
  parameter int Q_W   = 19
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic                  busy,
  output logic      [Q_W-1:0]   quot
);

  localparam int CNT_W = $clog2(Q_W + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [DEN_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [Q_W-1:0]   nsh_r;
  logic [Q_W-1:0]   quot_r;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   trial_sub;
  logic             ge;

  assign trial     = {rem_r, nsh_r[Q_W-1]};
  assign trial_sub = trial - {1'b0, den_r};
  assign ge        = (trial >= {1'b0, den_r});
  assign busy      = (cnt_r != '0);
  assign quot      = quot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (start) begin
      cnt_r <= CNT_W'(Q_W);
    end else if (busy) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // High part of the dividend is already below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      rem_r  <= DEN_W'(num >> Q_W);
      nsh_r  <= Q_W'(num);
      den_r  <= den;
      quot_r <= '0;
    end else if (busy) begin
      rem_r  <= ge ? trial_sub[DEN_W-1:0] : trial[DEN_W-1:0];
      nsh_r  <= {nsh_r[Q_W-2:0], 1'b0};
      quot_r <= {quot_r[Q_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

@@ sv/sliding_window_mean_variance.sv @@
// Sliding window mean and population variance of a signed sample stream.
// Depends on swmv_pkg, swmv_if (channels), swmv_ram and swmv_div.
//
// Usage:
//   in_ch carries one signed sample per transaction; out_ch returns one
//   result per sample: mean (8 fraction bits, rounded, ties away from zero),
//   population variance (8 fraction bits, rounded, clamped at zero) and the
//   count of samples covered (count so far until WINDOW samples are held).
//   A transaction completes when valid and ready are both high.
// Sequence:
//   One sample at a time: after acceptance a sample passes ST_UPD, ST_PROD,
//   ST_DIFF, ST_DIV (the bit-serial variance divider sets the wait) and ST_OUT,
//   which loads the output register. in_ch.ready rises with out_ch.valid, so
//   a new sample is only taken once the last result has been loaded.
// Reset (rst_n low, synchronous): sums, write pointer and full flag clear;
//   the sample RAM is not cleared, an old slot is only used once the window
//   has wrapped and every slot holds a sample.
// Stall: a result waits in the output register while out_ch.ready is low;
//   the next sample is still accepted and computed, and only the final load
//   of its result waits for the register to drain.
`timescale 1ns / 1ps
`default_nettype none

module sliding_window_mean_variance #(
  parameter int WINDOW      = 100,
  parameter int SAMPLE_BITS = 10
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  swmv_in_if.sink    in_ch,
  swmv_out_if.source out_ch
);

  import swmv_pkg::*;

  // Widths follow from exact bounds on the sums.
  localparam int IDX_W   = $clog2(WINDOW);
  localparam int N_W     = $clog2(WINDOW + 1);
  localparam int SUM_W   = SAMPLE_BITS + N_W;            // signed running sum
  localparam int ABS_W   = SUM_W - 1;                    // |sum|
  localparam int SQ_W    = 2 * SAMPLE_BITS - 1;          // one sample squared
  localparam int SSQ_W   = SQ_W + N_W;                   // running sum of squares
  localparam int PA_W    = N_W + SSQ_W;                  // n * sumsq
  localparam int SQS_W   = 2 * ABS_W;                    // sum * sum
  localparam int NN_W    = 2 * N_W;                      // n * n
  localparam int SH_W    = FRAC_BITS + 1;                // scale by 256, doubled for rounding
  localparam int MNUM_W  = ABS_W + SH_W + 1;
  localparam int MDEN_W  = N_W + 1;
  localparam int MQ_W    = SAMPLE_BITS + 9;              // |mean| * 256 <= 2^(SAMPLE_BITS+7)
  localparam int VNUM_W  = PA_W + SH_W + 1;
  localparam int VDEN_W  = NN_W + 1;
  localparam int VQ_W    = 2 * SAMPLE_BITS + 7;          // variance * 256 < 2^(2*SAMPLE_BITS+6)+1

  typedef enum logic [2:0] {
    ST_IDLE,   // waiting for a sample, RAM read issued on accept
    ST_UPD,    // old slot available: update sums, write new sample
    ST_PROD,   // register the products
    ST_DIFF,   // form dividends, start both dividers
    ST_DIV,    // wait for the dividers
    ST_OUT     // load output register
  } state_t;

  state_t state_r;

  // Control and running state
  logic [IDX_W-1:0]        idx_r;
  logic                    full_r;
  logic signed [SUM_W-1:0] sum_r;
  logic [SSQ_W-1:0]        ssq_r;
  logic [N_W-1:0]          n_r;

  // Datapath registers
  logic signed [SAMPLE_BITS-1:0] sample_r;
  logic [SQ_W-1:0]               sample_sq_r;
  logic [PA_W-1:0]               pa_r;
  logic [SQS_W-1:0]              sqs_r;
  logic [NN_W-1:0]               nn_r;
  logic [ABS_W-1:0]              abs_r;
  logic                          neg_r;

  // Output register
  logic                     out_valid_r;
  logic signed [MEAN_W-1:0] mean_r;
  logic [VAR_W-1:0]         var_r;
  logic [USED_W-1:0]        used_r;

  logic                            in_acc;
  logic [SAMPLE_W-1:0]             in_raw;
  logic signed [SAMPLE_BITS-1:0]   in_s;
  logic signed [2*SAMPLE_BITS-1:0] in_sq;
  logic [SAMPLE_BITS-1:0]          ram_rdata;
  logic signed [SAMPLE_BITS-1:0]   old_s;
  logic signed [2*SAMPLE_BITS-1:0] old_sq;
  logic signed [SUM_W-1:0]         sum_upd;
  logic [SSQ_W-1:0]                ssq_upd;
  logic [N_W-1:0]                  n_upd;
  logic                            idx_last;
  logic signed [2*SUM_W-1:0]       sum_sq;
  logic [PA_W-1:0]                 var_diff;
  logic [VNUM_W-1:0]               vnum;
  logic [VDEN_W-1:0]               vden;
  logic [MNUM_W-1:0]               mnum;
  logic [MDEN_W-1:0]               mden;
  logic                            div_start;
  logic                            mdiv_busy;
  logic                            vdiv_busy;
  logic [MQ_W-1:0]                 mquot;
  logic [VQ_W-1:0]                 vquot;
  logic signed [MQ_W:0]            mean_s;
  logic                            out_free;

  // Input side: take the low SAMPLE_BITS bits and sign-extend them.
  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign in_raw      = in_ch.sample_value;
  assign in_s        = signed'(SAMPLE_BITS'(in_raw));
  assign in_sq       = in_s * in_s;

  // Old slot: read on accept, data back in ST_UPD. The slot being
  // overwritten is the one that leaves the window.
  swmv_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (WINDOW)
  ) u_store (
    .clk     (clk),
    .wr_en   (state_r == ST_UPD),
    .wr_addr (idx_r),
    .wr_data (sample_r),
    .rd_en   (in_acc),
    .rd_addr (idx_r),
    .rd_data (ram_rdata)
  );

  assign old_s    = signed'(ram_rdata);
  assign old_sq   = old_s * old_s;
  assign sum_upd  = sum_r - (full_r ? SUM_W'(old_s) : SUM_W'(0)) + SUM_W'(sample_r);
  assign ssq_upd  = ssq_r - (full_r ? SSQ_W'(old_sq[SQ_W-1:0]) : SSQ_W'(0))
                    + SSQ_W'(sample_sq_r);
  assign n_upd    = full_r ? N_W'(WINDOW) : N_W'(idx_r) + N_W'(1);
  assign idx_last = (idx_r == IDX_W'(WINDOW - 1));

  // Square of the sum needs no sign handling.
  assign sum_sq = sum_r * sum_r;

  // n*sumsq >= sum^2 for exact sums; the compare keeps the clamp.
  assign var_diff = (pa_r > PA_W'(sqs_r)) ? pa_r - PA_W'(sqs_r) : '0;
  // round(x / d) computed as (2x + d) / (2d)
  assign vnum     = VNUM_W'({var_diff, {SH_W{1'b0}}}) + VNUM_W'(nn_r);
  assign vden     = {nn_r, 1'b0};
  assign mnum     = MNUM_W'({abs_r, {SH_W{1'b0}}}) + MNUM_W'(n_r);
  assign mden     = {n_r, 1'b0};
  assign div_start = (state_r == ST_DIFF);

  swmv_div #(
    .NUM_W (MNUM_W),
    .DEN_W (MDEN_W),
    .Q_W   (MQ_W)
  ) u_mean_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (mnum),
    .den   (mden),
    .busy  (mdiv_busy),
    .quot  (mquot)
  );

  swmv_div #(
    .NUM_W (VNUM_W),
    .DEN_W (VDEN_W),
    .Q_W   (VQ_W)
  ) u_var_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (vnum),
    .den   (vden),
    .busy  (vdiv_busy),
    .quot  (vquot)
  );

  // Magnitude rounding gives ties away from zero once the sign is restored.
  assign mean_s   = neg_r ? -signed'({1'b0, mquot}) : signed'({1'b0, mquot});
  assign out_free = !out_valid_r || out_ch.ready;

  // Datapath registers, no reset needed.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      sample_r    <= in_s;
      sample_sq_r <= in_sq[SQ_W-1:0];
    end
    if (state_r == ST_PROD) begin
      pa_r  <= n_r * ssq_r;
      sqs_r <= sum_sq[SQS_W-1:0];
      nn_r  <= n_r * n_r;
      neg_r <= sum_r[SUM_W-1];
      abs_r <= sum_r[SUM_W-1] ? ABS_W'(-sum_r) : ABS_W'(sum_r);
    end
  end

  // State machine, running state and output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      idx_r       <= '0;
      full_r      <= 1'b0;
      sum_r       <= '0;
      ssq_r       <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
      mean_r      <= '0;
      var_r       <= '0;
      used_r      <= '0;
    end else begin
      if (out_valid_r && out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            state_r <= ST_UPD;
          end
        end
        ST_UPD: begin
          sum_r <= sum_upd;
          ssq_r <= ssq_upd;
          n_r   <= n_upd;
          if (idx_last) begin
            idx_r  <= '0;
            full_r <= 1'b1;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
          state_r <= ST_PROD;
        end
        ST_PROD: begin
          state_r <= ST_DIFF;
        end
        ST_DIFF: begin
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (!mdiv_busy && !vdiv_busy) begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            mean_r      <= MEAN_W'(mean_s);
            var_r       <= VAR_W'(vquot);
            used_r      <= USED_W'(n_r);
            state_r     <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.window_mean     = mean_r;
  assign out_ch.window_variance = var_r;
  assign out_ch.samples_used    = used_r;

endmodule

`default_nettype wire

@@ sv/swmv_checker.sv @@
// Port-level checks for the sliding window mean/variance block, and the
// bind that attaches them. Depends on swmv_pkg and the defines header.
`timescale 1ns / 1ps
`default_nettype none
`include "sliding_window_mean_variance_defines.svh"

module swmv_checker #(
  parameter int WINDOW = 100
) (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [swmv_pkg::VAR_W-1:0]   window_variance,
  input wire logic [swmv_pkg::USED_W-1:0]  samples_used
);

  import swmv_pkg::*;

  // One sample in flight: ready drops right after a transaction.
  `SWMV_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready)

  // A result is held until taken.
  `SWMV_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

  // Count covers at least one sample and never exceeds the window.
  `SWMV_ASSERT_IMM(a_used_range, out_valid && WINDOW < 128, samples_used != 0 && samples_used <= WINDOW)

  // A single sample has zero variance.
  `SWMV_ASSERT_IMM(a_single_var, out_valid && samples_used == 1 && WINDOW < 128, window_variance == 0)

endmodule

bind sliding_window_mean_variance swmv_checker #(
  .WINDOW (WINDOW)
) u_swmv_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_valid        (in_ch.valid),
  .in_ready        (in_ch.ready),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .window_variance (out_ch.window_variance),
  .samples_used    (out_ch.samples_used)
);

`default_nettype wire
